// ===== rtl/lnss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lnss_pkg
// Shared types, widths and codes of the lattice neighbor shell sorter.
// ----------------------------------------------------------------------------
package lnss_pkg;

  localparam int DEF_MAX_ATOMS  = 16;
  localparam int DEF_MAX_SHIFT  = 2;
  localparam int DEF_MAX_POINTS = 2048;

  localparam int COORD_W    = 28;
  localparam int DISP_W     = 31;
  localparam int KEY_W      = 62;
  localparam int CNT_W      = 11;
  localparam int RADIUS_W   = 32;
  localparam int SHIFT_W    = 3;
  localparam int ATOM_W     = 4;
  localparam int ENTRY_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic signed [DISP_W-1:0] DISP_MAX = {1'b0, {(DISP_W-1){1'b1}}};
  localparam logic signed [DISP_W-1:0] DISP_MIN = {1'b1, {(DISP_W-1){1'b0}}};

  localparam logic [1:0] OP_LOAD_LAT = 2'd0;
  localparam logic [1:0] OP_LOAD_POS = 2'd1;
  localparam logic [1:0] OP_COMPUTE  = 2'd2;
  localparam logic [1:0] OP_READ     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ATOM_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_A      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_A      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_B      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_B      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_C      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_C      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL        = 3'd7;

  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_LOAD,
    MAC_SUB,
    MAC_MUL
  } mac_op_t;

  typedef struct packed {
    mac_op_t            op;
    logic signed [31:0] opa;
    logic signed [31:0] opb;
  } mac_req_t;

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic [ATOM_W-1:0]         atom;
    logic signed [SHIFT_W-1:0] sa;
    logic signed [SHIFT_W-1:0] sb;
    logic signed [SHIFT_W-1:0] sc;
    logic signed [DISP_W-1:0]  dx;
    logic signed [DISP_W-1:0]  dy;
    logic signed [DISP_W-1:0]  dz;
  } rec_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CTR_RD,
    ST_CTR_LATCH,
    ST_GEN_RD,
    ST_GEN_DISP,
    ST_GEN_SQ,
    ST_GEN_WR,
    ST_SORT_INIT,
    ST_M_GRP,
    ST_M_RD,
    ST_M_CMP,
    ST_SH_RD,
    ST_SH_START,
    ST_SH_WAIT,
    ST_SH_WR,
    ST_RD_MEM,
    ST_RD_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/lnss_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lnss_in_if
// Command channel: loads, compute and read requests.
// ----------------------------------------------------------------------------
interface lnss_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [3:0]         slot;
  logic signed [27:0] coord_x;
  logic signed [27:0] coord_y;
  logic signed [27:0] coord_z;
  logic [3:0]         center_atom;
  logic [10:0]        entry_number;

  modport source (output valid, op, slot, coord_x, coord_y, coord_z, center_atom,
                  entry_number, input ready);
  modport sink (input valid, op, slot, coord_x, coord_y, coord_z, center_atom,
                entry_number, output ready);
endinterface
`default_nettype wire

// ===== rtl/lnss_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lnss_out_if
// Result channel: one sorted neighbor entry per transaction.
// ----------------------------------------------------------------------------
interface lnss_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        radius;
  logic signed [2:0]  shift_a;
  logic signed [2:0]  shift_b;
  logic signed [2:0]  shift_c;
  logic [3:0]         neighbor_atom;
  logic signed [30:0] disp_x;
  logic signed [30:0] disp_y;
  logic signed [30:0] disp_z;
  logic [10:0]        shell_number;
  logic [10:0]        rank_in_shell;
  logic               entry_valid;

  modport source (output valid, radius, shift_a, shift_b, shift_c, neighbor_atom,
                  disp_x, disp_y, disp_z, shell_number, rank_in_shell, entry_valid,
                  input ready);
  modport sink (input valid, radius, shift_a, shift_b, shift_c, neighbor_atom,
                disp_x, disp_y, disp_z, shell_number, rank_in_shell, entry_valid,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/lnss_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lnss_mac
// Shared multiply-accumulate unit with 31-bit saturating view of the sum.
// ----------------------------------------------------------------------------
module lnss_mac import lnss_pkg::*; (
  input  logic                     clk,
  input  mac_req_t                 req,
  output logic signed [63:0]       acc,
  output logic signed [DISP_W-1:0] acc_sat
);

  logic signed [63:0] acc_r;
  logic signed [63:0] prod;

  always_comb begin
    prod = req.opa * req.opb;
  end

  always_ff @(posedge clk) begin
    case (req.op)
      MAC_LOAD: acc_r <= 64'(req.opa);
      MAC_SUB:  acc_r <= acc_r - 64'(req.opa);
      MAC_MUL:  acc_r <= acc_r + prod;
      default:  acc_r <= acc_r;
    endcase
  end

  always_comb begin
    if (acc_r > 64'(DISP_MAX)) begin
      acc_sat = DISP_MAX;
    end else if (acc_r < 64'(DISP_MIN)) begin
      acc_sat = DISP_MIN;
    end else begin
      acc_sat = acc_r[DISP_W-1:0];
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

// ===== rtl/lnss_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lnss_isqrt
// Iterative floor square root of a 64-bit value, two radicand bits a cycle.
// ----------------------------------------------------------------------------
module lnss_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic        busy_r;
  logic        done_r;
  logic [63:0] rem_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [63:0] trial;
  logic        fits;

  assign trial = res_r + bit_r;
  assign fits  = rem_r >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r == 64'd1) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= radicand;
      res_r <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule
`default_nettype wire

// ===== rtl/lnss_sort_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lnss_sort_ram
// One bank of point records: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module lnss_sort_ram import lnss_pkg::*; #(
  parameter int DEPTH = DEF_MAX_POINTS,
  parameter int AW    = $clog2(DEF_MAX_POINTS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  rec_t          wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output rec_t          rdata_a,
  output rec_t          rdata_b
);

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// ===== rtl/lattice_neighbor_shell_sort.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lattice_neighbor_shell_sort
// Periodic neighbor search: generate, stable sort and shell-label images.
// ----------------------------------------------------------------------------
// Usage. in_ch carries commands: load lattice row, load atom position,
// compute for a centre atom, read a sorted entry. Every command is one
// transaction; ready is high only while the sequencer is idle. A read
// returns one transaction on out_ch; the result sits in an output
// register, so the next command is taken while it waits for a stalled
// receiver. Reads before a compute, or beyond the point count, return
// all-zero fields with entry_valid low. A compute over N points runs
// generation (the shared multiply-accumulate unit does every lattice
// term and square), ceil(log2 N) merge passes (two-port bank reads feed
// each compare) and shell labeling (the iterative square root). Any load
// or configuration write invalidates the table. Reset clears the lattice
// rows, position valid bits and point count and resets the configuration;
// no clearing pass is run. Configuration (cfg_we/cfg_index/cfg_data) is to
// be written only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module lattice_neighbor_shell_sort import lnss_pkg::*; #(
  parameter int MAX_ATOMS  = DEF_MAX_ATOMS,
  parameter int MAX_SHIFT  = DEF_MAX_SHIFT,
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lnss_in_if.sink               in_ch,
  lnss_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW   = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int NAW  = ($clog2(MAX_ATOMS + 1) > 5) ? $clog2(MAX_ATOMS + 1) : 5;
  localparam int PAW  = $clog2(MAX_POINTS);
  localparam int PCW  = $clog2(MAX_POINTS + 1);
  localparam int MW   = PAW + 2;
  localparam int EW   = (PCW > ENTRY_W) ? PCW : ENTRY_W;
  localparam int SHW  = RADIUS_W + 2 * CNT_W;
  localparam logic signed [3:0] MS4 = 4'(MAX_SHIFT);

  function automatic logic signed [3:0] clamp_lo(input logic [1:0] m);
    logic signed [3:0] v;
    v = {{2{m[1]}}, m};
    if (v > 4'sd0) v = 4'sd0;
    else if (v < -MS4) v = -MS4;
    return v;
  endfunction

  function automatic logic signed [3:0] clamp_hi(input logic [1:0] m);
    logic signed [3:0] v;
    v = {2'b00, m};
    if (v > MS4) v = MS4;
    return v;
  endfunction

  // configuration
  logic [4:0]  cfg_atom_count_r;
  logic [1:0]  cfg_min_a_r, cfg_max_a_r, cfg_min_b_r, cfg_max_b_r;
  logic [1:0]  cfg_min_c_r, cfg_max_c_r;
  logic [15:0] cfg_tol_r;

  // control
  state_t            state_r, state_nxt;
  logic              table_ready_r;
  logic [PCW-1:0]    count_r;
  logic [PCW-1:0]    z_r;
  logic [NAW-1:0]    atom_r;
  logic signed [3:0] sa_r, sb_r, sc_r;
  logic [2:0]        step_r;
  logic [1:0]        comp_r;
  logic [3:0]        ctr_r;
  logic [MW-1:0]     w_r, lo_r, mid_r, hi_r, a_r, b_r, k_r;
  logic              sel_r;
  logic [CNT_W-1:0]  shell_r, rank_r;
  logic [31:0]       rprev_r;
  logic [ENTRY_W-1:0] e_r;
  logic              rd_ok_r;
  logic              out_valid_r, out_valid_nxt;

  // stores
  logic signed [COORD_W-1:0]   lat_r [9];
  logic [3*COORD_W-1:0]        pos_mem [MAX_ATOMS];
  logic [MAX_ATOMS-1:0]        pos_vld_r;
  logic [3*COORD_W-1:0]        pos_rd_r;
  logic                        pos_rv_r;
  logic signed [COORD_W-1:0]   cpos_r [3];
  logic signed [DISP_W-1:0]    d_r [3];
  logic [SHW-1:0]              shell_mem [MAX_POINTS];
  logic [SHW-1:0]              sh_rd_r;

  // output payload
  logic [31:0]        o_radius_r;
  logic signed [2:0]  o_sa_r, o_sb_r, o_sc_r;
  logic [3:0]         o_atom_r;
  logic signed [30:0] o_dx_r, o_dy_r, o_dz_r;
  logic [10:0]        o_shell_r, o_rank_r;
  logic               o_ev_r;

  // effective ranges
  logic [NAW-1:0]    na;
  logic signed [3:0] lo_a, hi_a, lo_b, hi_b, lo_c, hi_c;

  always_comb begin
    if (cfg_atom_count_r == 5'd0) na = NAW'(1);
    else if (NAW'(cfg_atom_count_r) > NAW'(MAX_ATOMS)) na = NAW'(MAX_ATOMS);
    else na = NAW'(cfg_atom_count_r);
    lo_a = clamp_lo(cfg_min_a_r);
    lo_b = clamp_lo(cfg_min_b_r);
    lo_c = clamp_lo(cfg_min_c_r);
    hi_a = clamp_hi(cfg_max_a_r);
    hi_b = clamp_hi(cfg_max_b_r);
    hi_c = clamp_hi(cfg_max_c_r);
  end

  // handshakes
  logic in_acc, out_acc, out_free;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_acc  = out_valid_r && out_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // position store read
  logic [AW-1:0]             pos_raddr;
  logic                      ctr_oob;
  logic [3*COORD_W-1:0]      prow;
  logic signed [COORD_W-1:0] pos_comp;

  assign ctr_oob   = 32'(ctr_r) >= MAX_ATOMS;
  assign pos_raddr = (state_r == ST_CTR_RD || state_r == ST_CTR_LATCH) ? AW'(ctr_r)
                                                                       : atom_r[AW-1:0];
  assign prow      = pos_rv_r ? pos_rd_r : '0;

  always_comb begin
    case (comp_r)
      2'd0:    pos_comp = $signed(prow[COORD_W-1:0]);
      2'd1:    pos_comp = $signed(prow[2*COORD_W-1:COORD_W]);
      default: pos_comp = $signed(prow[3*COORD_W-1:2*COORD_W]);
    endcase
  end

  // shared units
  mac_req_t                 mac_req;
  logic signed [63:0]       mac_acc;
  logic signed [DISP_W-1:0] mac_sat;
  logic                     sq_start, sq_done;
  logic [31:0]              sq_root;

  lnss_mac u_mac (
    .clk     (clk),
    .req     (mac_req),
    .acc     (mac_acc),
    .acc_sat (mac_sat)
  );

  rec_t  b0_a, b0_b, b1_a, b1_b, src_a, src_b, bank_wdata, gen_rec;
  logic  gen_we, mrg_we, b0_we, b1_we;
  logic [PAW-1:0] bank_waddr, bank_raddr_a, bank_raddr_b;

  lnss_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand ({2'b00, src_a.key}),
    .done     (sq_done),
    .root     (sq_root)
  );

  lnss_sort_ram #(.DEPTH(MAX_POINTS), .AW(PAW)) u_bank0 (
    .clk (clk), .we (b0_we), .waddr (bank_waddr), .wdata (bank_wdata),
    .raddr_a (bank_raddr_a), .raddr_b (bank_raddr_b), .rdata_a (b0_a), .rdata_b (b0_b)
  );

  lnss_sort_ram #(.DEPTH(MAX_POINTS), .AW(PAW)) u_bank1 (
    .clk (clk), .we (b1_we), .waddr (bank_waddr), .wdata (bank_wdata),
    .raddr_a (bank_raddr_a), .raddr_b (bank_raddr_b), .rdata_a (b1_a), .rdata_b (b1_b)
  );

  // source bank holds the current pass; after the sort it holds the table
  assign src_a = sel_r ? b1_a : b0_a;
  assign src_b = sel_r ? b1_b : b0_b;

  // sequencer conditions
  logic          atom_last, gen_stop, k_last, pass_end, sort_end, take_a, sh_last;
  logic [MW-1:0] n_m, nlo;
  logic [PCW-1:0] z_inc;
  logic [31:0]   rdiff;
  logic [CNT_W-1:0] shell_n, rank_n;

  always_comb begin
    z_inc     = z_r + 1'b1;
    atom_last = atom_r == na - 1'b1;
    gen_stop  = (32'(z_inc) == MAX_POINTS) ||
                (atom_last && sc_r == hi_c && sb_r == hi_b && sa_r == hi_a);
    n_m       = MW'(count_r);
    nlo       = lo_r + (w_r << 1);
    k_last    = MW'(k_r + 1'b1) == hi_r;
    pass_end  = nlo >= n_m;
    sort_end  = (w_r << 1) >= n_m;
    take_a    = (a_r < mid_r) && (!(b_r < hi_r) || src_a.key <= src_b.key);
    sh_last   = z_inc == count_r;
    rdiff     = sq_root - rprev_r;
    if (z_r == '0) begin
      shell_n = '0;
      rank_n  = CNT_W'(1);
    end else if (rdiff < {16'd0, cfg_tol_r}) begin
      shell_n = shell_r;
      rank_n  = (rank_r < CNT_MAX) ? rank_r + 1'b1 : rank_r;
    end else begin
      shell_n = (shell_r < CNT_MAX) ? shell_r + 1'b1 : shell_r;
      rank_n  = CNT_W'(1);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_ch.op == OP_COMPUTE) state_nxt = ST_CTR_RD;
        else if (in_acc && in_ch.op == OP_READ) state_nxt = ST_RD_MEM;
      end
      ST_CTR_RD:    state_nxt = ST_CTR_LATCH;
      ST_CTR_LATCH: state_nxt = ST_GEN_RD;
      ST_GEN_RD:    state_nxt = ST_GEN_DISP;
      ST_GEN_DISP: begin
        if (step_r == 3'd5 && comp_r == 2'd2) state_nxt = ST_GEN_SQ;
      end
      ST_GEN_SQ: begin
        if (step_r == 3'd3) state_nxt = ST_GEN_WR;
      end
      ST_GEN_WR:    state_nxt = gen_stop ? ST_SORT_INIT : ST_GEN_RD;
      ST_SORT_INIT: state_nxt = (count_r <= PCW'(1)) ? ST_SH_RD : ST_M_GRP;
      ST_M_GRP:     state_nxt = ST_M_RD;
      ST_M_RD:      state_nxt = ST_M_CMP;
      ST_M_CMP: begin
        if (k_last && pass_end && sort_end) state_nxt = ST_SH_RD;
        else if (k_last) state_nxt = ST_M_GRP;
        else state_nxt = ST_M_RD;
      end
      ST_SH_RD:     state_nxt = ST_SH_START;
      ST_SH_START:  state_nxt = ST_SH_WAIT;
      ST_SH_WAIT: begin
        if (sq_done) state_nxt = ST_SH_WR;
      end
      ST_SH_WR:     state_nxt = sh_last ? ST_IDLE : ST_SH_RD;
      ST_RD_MEM:    state_nxt = ST_RD_OUT;
      ST_RD_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  logic [3:0] lat_idx;
  logic [1:0] sq_idx;

  always_comb begin
    mac_req      = '{op: MAC_HOLD, opa: '0, opb: '0};
    gen_we       = 1'b0;
    mrg_we       = 1'b0;
    sq_start     = 1'b0;
    lat_idx      = 4'(comp_r);
    sq_idx       = 2'(step_r - 3'd1);
    case (state_r)
      ST_GEN_DISP: begin
        case (step_r)
          3'd0: mac_req = '{op: MAC_LOAD, opa: 32'(pos_comp), opb: '0};
          3'd1: mac_req = '{op: MAC_SUB, opa: 32'(cpos_r[comp_r]), opb: '0};
          3'd2: mac_req = '{op: MAC_MUL, opa: 32'(lat_r[lat_idx]), opb: 32'(sa_r)};
          3'd3: begin
            lat_idx = 4'(comp_r) + 4'd3;
            mac_req = '{op: MAC_MUL, opa: 32'(lat_r[lat_idx]), opb: 32'(sb_r)};
          end
          3'd4: begin
            lat_idx = 4'(comp_r) + 4'd6;
            mac_req = '{op: MAC_MUL, opa: 32'(lat_r[lat_idx]), opb: 32'(sc_r)};
          end
          default: mac_req = '{op: MAC_HOLD, opa: '0, opb: '0};
        endcase
      end
      ST_GEN_SQ: begin
        if (step_r == 3'd0) begin
          mac_req = '{op: MAC_LOAD, opa: '0, opb: '0};
        end else begin
          mac_req = '{op: MAC_MUL, opa: 32'(d_r[sq_idx]), opb: 32'(d_r[sq_idx])};
        end
      end
      ST_GEN_WR:   gen_we   = 1'b1;
      ST_M_CMP:    mrg_we   = 1'b1;
      ST_SH_START: sq_start = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    gen_rec = '{key: mac_acc[KEY_W-1:0], atom: ATOM_W'(atom_r), sa: sa_r[2:0],
                sb: sb_r[2:0], sc: sc_r[2:0], dx: d_r[0], dy: d_r[1], dz: d_r[2]};
    case (state_r)
      ST_SH_RD, ST_SH_START, ST_SH_WAIT, ST_SH_WR: bank_raddr_a = PAW'(z_r);
      ST_RD_MEM, ST_RD_OUT:                      bank_raddr_a = PAW'(e_r);
      default:                                   bank_raddr_a = PAW'(a_r);
    endcase
  end

  assign bank_raddr_b = PAW'(b_r);
  assign bank_waddr   = gen_we ? PAW'(z_r) : PAW'(k_r);
  assign bank_wdata   = gen_we ? gen_rec : (take_a ? src_a : src_b);
  // generation fills bank 0; each merge pass writes the bank it does not read
  assign b0_we        = gen_we || (mrg_we && sel_r);
  assign b1_we        = mrg_we && !sel_r;
  assign in_ch.ready  = state_r == ST_IDLE;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_acc;
    if (state_r == ST_RD_OUT && out_free) out_valid_nxt = 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      out_valid_r      <= 1'b0;
      table_ready_r    <= 1'b0;
      count_r          <= '0;
      pos_vld_r        <= '0;
      cfg_atom_count_r <= 5'd1;
      cfg_min_a_r      <= '0;
      cfg_max_a_r      <= '0;
      cfg_min_b_r      <= '0;
      cfg_max_b_r      <= '0;
      cfg_min_c_r      <= '0;
      cfg_max_c_r      <= '0;
      cfg_tol_r        <= 16'd7;
      for (int i = 0; i < 9; i++) lat_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        table_ready_r <= 1'b0;
        case (cfg_index)
          CFG_ATOM_COUNT: cfg_atom_count_r <= cfg_data[4:0];
          CFG_MIN_A:      cfg_min_a_r      <= cfg_data[1:0];
          CFG_MAX_A:      cfg_max_a_r      <= cfg_data[1:0];
          CFG_MIN_B:      cfg_min_b_r      <= cfg_data[1:0];
          CFG_MAX_B:      cfg_max_b_r      <= cfg_data[1:0];
          CFG_MIN_C:      cfg_min_c_r      <= cfg_data[1:0];
          CFG_MAX_C:      cfg_max_c_r      <= cfg_data[1:0];
          CFG_TOL:        cfg_tol_r        <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc && in_ch.op == OP_LOAD_LAT) begin
        table_ready_r <= 1'b0;
        for (int j = 0; j < 3; j++) begin
          if (in_ch.slot == 4'(j)) begin
            lat_r[3*j]     <= in_ch.coord_x;
            lat_r[3*j + 1] <= in_ch.coord_y;
            lat_r[3*j + 2] <= in_ch.coord_z;
          end
        end
      end
      if (in_acc && in_ch.op == OP_LOAD_POS) begin
        table_ready_r <= 1'b0;
        if (32'(in_ch.slot) < MAX_ATOMS) pos_vld_r[AW'(in_ch.slot)] <= 1'b1;
      end
      if (state_r == ST_GEN_WR && gen_stop) count_r <= z_inc;
      if (state_r == ST_SH_WR && sh_last) table_ready_r <= 1'b1;
    end
  end

  // position store: written by loads, read one row a cycle
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.op == OP_LOAD_POS && 32'(in_ch.slot) < MAX_ATOMS) begin
      pos_mem[AW'(in_ch.slot)] <= {in_ch.coord_z, in_ch.coord_y, in_ch.coord_x};
    end
    pos_rd_r <= pos_mem[pos_raddr];
    pos_rv_r <= pos_vld_r[pos_raddr];
  end

  // shell table
  always_ff @(posedge clk) begin
    if (state_r == ST_SH_WR) shell_mem[PAW'(z_r)] <= {sq_root, shell_n, rank_n};
    sh_rd_r <= shell_mem[PAW'(e_r)];
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        ctr_r  <= in_ch.center_atom;
        e_r    <= in_ch.entry_number;
        rd_ok_r <= table_ready_r && (EW'(in_ch.entry_number) < EW'(count_r));
        atom_r <= '0;
        sa_r   <= lo_a;
        sb_r   <= lo_b;
        sc_r   <= lo_c;
        z_r    <= '0;
        step_r <= '0;
        comp_r <= '0;
      end
      ST_CTR_LATCH: begin
        // an out-of-range centre sits at the origin
        cpos_r[0] <= ctr_oob ? '0 : $signed(prow[COORD_W-1:0]);
        cpos_r[1] <= ctr_oob ? '0 : $signed(prow[2*COORD_W-1:COORD_W]);
        cpos_r[2] <= ctr_oob ? '0 : $signed(prow[3*COORD_W-1:2*COORD_W]);
      end
      ST_GEN_DISP: begin
        if (step_r == 3'd5) begin
          d_r[comp_r] <= mac_sat;
          step_r      <= '0;
          comp_r      <= (comp_r == 2'd2) ? 2'd0 : comp_r + 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
      ST_GEN_SQ: begin
        step_r <= (step_r == 3'd3) ? 3'd0 : step_r + 1'b1;
      end
      ST_GEN_WR: begin
        // advance: atom fastest, then c, then b, then a
        z_r <= z_inc;
        if (!atom_last) begin
          atom_r <= atom_r + 1'b1;
        end else begin
          atom_r <= '0;
          if (sc_r != hi_c) begin
            sc_r <= sc_r + 4'sd1;
          end else begin
            sc_r <= lo_c;
            if (sb_r != hi_b) begin
              sb_r <= sb_r + 4'sd1;
            end else begin
              sb_r <= lo_b;
              sa_r <= sa_r + 4'sd1;
            end
          end
        end
      end
      ST_SORT_INIT: begin
        w_r   <= MW'(1);
        lo_r  <= '0;
        sel_r <= 1'b0;
        z_r   <= '0;
      end
      ST_M_GRP: begin
        mid_r <= (lo_r + w_r < n_m) ? lo_r + w_r : n_m;
        hi_r  <= (nlo < n_m) ? nlo : n_m;
        a_r   <= lo_r;
        b_r   <= (lo_r + w_r < n_m) ? lo_r + w_r : n_m;
        k_r   <= lo_r;
      end
      ST_M_CMP: begin
        if (take_a) a_r <= a_r + 1'b1;
        else b_r <= b_r + 1'b1;
        k_r <= k_r + 1'b1;
        if (k_last) begin
          if (pass_end) begin
            sel_r <= !sel_r;
            w_r   <= w_r << 1;
            lo_r  <= '0;
            z_r   <= '0;
          end else begin
            lo_r <= nlo;
          end
        end
      end
      ST_SH_WR: begin
        shell_r <= shell_n;
        rank_r  <= rank_n;
        rprev_r <= sq_root;
        z_r     <= z_inc;
      end
      ST_RD_OUT: begin
        if (out_free) begin
          o_radius_r <= rd_ok_r ? sh_rd_r[SHW-1:2*CNT_W] : '0;
          o_shell_r  <= rd_ok_r ? sh_rd_r[2*CNT_W-1:CNT_W] : '0;
          o_rank_r   <= rd_ok_r ? sh_rd_r[CNT_W-1:0] : '0;
          o_sa_r     <= rd_ok_r ? src_a.sa : '0;
          o_sb_r     <= rd_ok_r ? src_a.sb : '0;
          o_sc_r     <= rd_ok_r ? src_a.sc : '0;
          o_atom_r   <= rd_ok_r ? src_a.atom : '0;
          o_dx_r     <= rd_ok_r ? src_a.dx : '0;
          o_dy_r     <= rd_ok_r ? src_a.dy : '0;
          o_dz_r     <= rd_ok_r ? src_a.dz : '0;
          o_ev_r     <= rd_ok_r;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.radius        = o_radius_r;
  assign out_ch.shift_a       = o_sa_r;
  assign out_ch.shift_b       = o_sb_r;
  assign out_ch.shift_c       = o_sc_r;
  assign out_ch.neighbor_atom = o_atom_r;
  assign out_ch.disp_x        = o_dx_r;
  assign out_ch.disp_y        = o_dy_r;
  assign out_ch.disp_z        = o_dz_r;
  assign out_ch.shell_number  = o_shell_r;
  assign out_ch.rank_in_shell = o_rank_r;
  assign out_ch.entry_valid   = o_ev_r;

  // a result transaction is only raised by the read sequence
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RD_OUT))
    else $error("result raised outside a read");

  // the square root finishes only while the labeler waits for it
  a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> state_r == ST_SH_WAIT)
    else $error("square root finished out of sequence");

  // every merge write lands inside its group
  a_merge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_M_CMP |-> (k_r < hi_r) && (a_r <= mid_r) && (b_r <= hi_r))
    else $error("merge index out of group");

  // a ready table always holds at least one point
  a_ready_count: assert property (@(posedge clk) disable iff (!rst_n)
    table_ready_r |-> count_r != '0)
    else $error("table ready with no points");

endmodule
`default_nettype wire
